/* rtl/avm_pkg.sv */
// Shared opcodes, strobe group and stream packing constants for the accumulator VM execute block.
package avm_pkg;

   // Instruction codes; 2, 4 and 13 are reserved, OP_LIMIT and above halt.
   typedef enum logic [4:0] {
      OP_NOP  = 5'd0,
      OP_LDI  = 5'd1,
      OP_LD   = 5'd3,
      OP_ST   = 5'd5,
      OP_LT   = 5'd6,
      OP_GT   = 5'd7,
      OP_EQI  = 5'd8,
      OP_EQ   = 5'd9,
      OP_BZ   = 5'd10,
      OP_BNZ  = 5'd11,
      OP_DLY  = 5'd12,
      OP_LTE  = 5'd14,
      OP_GTE  = 5'd15,
      OP_HALT = 5'd16,
      OP_JMP  = 5'd17,
      OP_ADDI = 5'd18,
      OP_ADD  = 5'd19,
      OP_SUBI = 5'd20,
      OP_SUB  = 5'd21
   } opcode_type;

   localparam logic [4:0] OP_LIMIT = 5'd22;

   typedef struct packed {
      logic delay;
      logic store;
   } strobe_type;

   // Field widths of the stream payloads.
   localparam int OPCODE_W  = 5;
   localparam int VALUE_W   = 32;
   localparam int ADDR_W    = 8;
   localparam int FLAG_W    = 1;

   localparam int REQ_TDATA_W = 56;   // 53 bits of fields, padded to bytes
   localparam int RSP_TDATA_W = 120;  // 113 bits of fields, padded to bytes
   localparam int RSP_TUSER_W = 2;

endpackage

/* rtl/avm_exec.sv */
// Combinational execute logic: decodes one instruction and computes the next machine state.
module avm_exec
   import avm_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int PC_WIDTH   = 8
) (
   input  logic [OPCODE_W-1:0]   opcode,
   input  logic [VALUE_W-1:0]    operand_value,
   input  logic [ADDR_W-1:0]     branch_target,
   input  logic [PC_WIDTH-1:0]   pc,
   input  logic [DATA_WIDTH-1:0] acc,
   input  logic                  halt,
   output logic [PC_WIDTH-1:0]   pc_next,
   output logic [DATA_WIDTH-1:0] acc_next,
   output logic                  halt_next,
   output strobe_type            strobe
);

   logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
   logic [PC_WIDTH+ADDR_W-1:0]    target_wide;
   logic [DATA_WIDTH-1:0]         value;
   logic [PC_WIDTH-1:0]           target;
   logic [PC_WIDTH-1:0]           pc_inc;
   logic [DATA_WIDTH-1:0]         acc_one;
   logic [DATA_WIDTH-1:0]         acc_zero;
   logic                          acc_lt;
   logic                          acc_gt;
   logic                          acc_eq;
   logic                          acc_is_zero;

   // Sign-extend or truncate the operand to the datapath width.
   assign value_wide  = {{DATA_WIDTH{operand_value[VALUE_W-1]}}, operand_value};
   assign value       = value_wide[DATA_WIDTH-1:0];
   assign target_wide = {{PC_WIDTH{1'b0}}, branch_target};
   assign target      = target_wide[PC_WIDTH-1:0];

   assign pc_inc      = pc + {{(PC_WIDTH-1){1'b0}}, 1'b1};
   assign acc_one     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
   assign acc_zero    = '0;
   assign acc_lt      = $signed(acc) < $signed(value);
   assign acc_gt      = $signed(value) < $signed(acc);
   assign acc_eq      = (acc == value);
   assign acc_is_zero = (acc == acc_zero);

   always_comb begin
      pc_next   = pc;
      acc_next  = acc;
      halt_next = halt;
      strobe    = '0;
      if (!halt) begin
         case (opcode)
            OP_NOP: begin
               pc_next = pc_inc;
            end
            OP_LDI, OP_LD: begin
               acc_next = value;
               pc_next  = pc_inc;
            end
            OP_ST: begin
               strobe.store = 1'b1;
               pc_next      = pc_inc;
            end
            OP_LT: begin
               acc_next = acc_lt ? acc_one : acc_zero;
               pc_next  = pc_inc;
            end
            OP_GT: begin
               acc_next = acc_gt ? acc_one : acc_zero;
               pc_next  = pc_inc;
            end
            OP_EQI, OP_EQ: begin
               acc_next = acc_eq ? acc_one : acc_zero;
               pc_next  = pc_inc;
            end
            OP_BZ: begin
               pc_next = acc_is_zero ? target : pc_inc;
            end
            OP_BNZ: begin
               pc_next = acc_is_zero ? pc_inc : target;
            end
            OP_DLY: begin
               strobe.delay = 1'b1;
               pc_next      = pc_inc;
            end
            OP_LTE: begin
               acc_next = acc_gt ? acc_zero : acc_one;
               pc_next  = pc_inc;
            end
            OP_GTE: begin
               acc_next = acc_lt ? acc_zero : acc_one;
               pc_next  = pc_inc;
            end
            OP_HALT: begin
               halt_next = 1'b1;
            end
            OP_JMP: begin
               pc_next = target;
            end
            OP_ADDI, OP_ADD: begin
               acc_next = acc + value;
               pc_next  = pc_inc;
            end
            OP_SUBI, OP_SUB: begin
               acc_next = acc - value;
               pc_next  = pc_inc;
            end
            default: begin
               // Reserved codes change nothing; codes past the table halt.
               if (opcode >= OP_LIMIT) begin
                  halt_next = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

/* rtl/accumulator_vm_execute.sv */
// Top level of the accumulator VM execute block: input stage, execute, result stage.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | opcode, operand, branch target, entry
//  rsp     | out | rsp_tvalid/rsp_tready | pc, accumulator, halted, store/delay data
//
//  One instruction per cycle while rsp is not stalled; rsp_tvalid rises once the
//  result stage registers its result. The pc/accumulator/halt feedback through
//  the execute logic sets the rate: each instruction sees its predecessor's state.
//  Reset clears pc, accumulator and halt flag and empties both stages.
//  A stalled rsp holds its result; the input stage still takes one more item,
//  and req_tready drops only when both stages are full and rsp is stalled.
module accumulator_vm_execute
   import avm_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int PC_WIDTH   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [4:0] opcode, [36:5] operand_value, [44:37] branch_target,
   // [52:45] entry_index, [55:53] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] next_pc, [39:8] acc_value, [40] halted, [48:41] store_entry,
   // [80:49] store_data, [112:81] delay_ticks, [119:113] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] store_strobe, [1] delay_strobe
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // Input stage
   logic                  req_valid_ff;
   logic                  req_valid_in;
   logic [OPCODE_W-1:0]   opcode_ff;
   logic [VALUE_W-1:0]    operand_ff;
   logic [ADDR_W-1:0]     target_ff;
   logic [ADDR_W-1:0]     entry_ff;

   // Machine state
   logic [PC_WIDTH-1:0]   pc_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic                  halt_ff;
   logic [PC_WIDTH-1:0]   pc_in;
   logic [DATA_WIDTH-1:0] acc_in;
   logic                  halt_in;
   strobe_type            strobe;

   // Result stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_in;

   logic                   req_take;
   logic                   exec_go;

   logic [PC_WIDTH+ADDR_W-1:0]    pc_wide;
   logic [DATA_WIDTH+VALUE_W-1:0] acc_wide;
   logic [ADDR_W-1:0]             pc_out;
   logic [VALUE_W-1:0]            acc_out;
   logic [ADDR_W-1:0]             store_entry;
   logic [VALUE_W-1:0]            store_data;
   logic [VALUE_W-1:0]            delay_ticks;

   // Execute when an instruction waits and the result stage is free or draining.
   assign exec_go    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || exec_go;
   assign req_take   = req_tvalid && req_tready;

   assign req_valid_in = req_take || (req_valid_ff && !exec_go);
   assign rsp_valid_in = exec_go || (rsp_valid_ff && !rsp_tready);

   avm_exec #(
      .DATA_WIDTH (DATA_WIDTH),
      .PC_WIDTH   (PC_WIDTH)
   ) u_exec (
      .opcode        (opcode_ff),
      .operand_value (operand_ff),
      .branch_target (target_ff),
      .pc            (pc_ff),
      .acc           (acc_ff),
      .halt          (halt_ff),
      .pc_next       (pc_in),
      .acc_next      (acc_in),
      .halt_next     (halt_in),
      .strobe        (strobe)
   );

   // Fit pc and accumulator to the result field widths (zero-extend or drop high bits).
   assign pc_wide     = {{ADDR_W{1'b0}}, pc_in};
   assign pc_out      = pc_wide[ADDR_W-1:0];
   assign acc_wide    = {{VALUE_W{1'b0}}, acc_in};
   assign acc_out     = acc_wide[VALUE_W-1:0];
   assign store_entry = strobe.store ? entry_ff : '0;
   assign store_data  = strobe.store ? acc_out : '0;
   assign delay_ticks = strobe.delay ? acc_out : '0;

   assign rsp_tdata_in = {7'b0, delay_ticks, store_data, store_entry, halt_in, acc_out, pc_out};
   assign rsp_tuser_in = {strobe.delay, strobe.store};

   // Control state and machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         acc_ff       <= '0;
         halt_ff      <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            pc_ff   <= pc_in;
            acc_ff  <= acc_in;
            halt_ff <= halt_in;
         end
      end
   end

   // Payload: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff  <= req_tdata[4:0];
         operand_ff <= req_tdata[36:5];
         target_ff  <= req_tdata[44:37];
         entry_ff   <= req_tdata[52:45];
      end
      if (exec_go) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* sim/accumulator_vm_execute_tb.sv */
// Self-checking stream testbench for the accumulator VM execute block.
module accumulator_vm_execute_tb;
   import avm_pkg::*;

   // Reserved codes: the machine leaves every piece of state as it is.
   localparam logic [4:0] OP_RSV_A = 5'd2;
   localparam logic [4:0] OP_RSV_B = 5'd4;
   localparam logic [4:0] OP_RSV_C = 5'd13;
   localparam logic [4:0] OP_TOP   = 5'd31;

   localparam int DIR_ROWS    = 27;
   localparam int RAND_ITEMS  = 1300;
   localparam int CALM_ITEMS  = 200;  // tail of the random part without idling
   localparam int AFTER_HALT  = 24;   // items thrown at the halted machine

   // One result as the rsp channel carries it, unpacked.
   typedef struct packed {
      logic [7:0]  pc;
      logic [31:0] acc;
      logic        halted;
      logic        st;
      logic [7:0]  entry;
      logic [31:0] sdata;
      logic        dl;
      logic [31:0] ticks;
   } outcome_type;

   // One directed instruction; typed rows carry a hand-written outcome.
   typedef struct packed {
      logic [4:0]  op;
      logic [31:0] val;
      logic [7:0]  tgt;
      logic [7:0]  ent;
      logic        typed;
      outcome_type want;
   } instr_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // Shadow machine state, advanced once per req transfer.
   logic [7:0]  vm_pc      = '0;
   logic [31:0] vm_acc     = '0;
   logic        vm_halted  = 1'b0;
   logic [31:0] executed_ops = '0;

   outcome_type   vm_results_due [$];
   instr_row_type dir_tbl [DIR_ROWS];
   int          mismatch_count = 0;
   int          results_seen   = 0;
   int          ignored_items  = 0;
   int          store_hits     = 0;
   int          delay_hits     = 0;
   int          rsp_stall_left = 0;
   bit          idle_off       = 1'b0;

   accumulator_vm_execute u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Outcome with no strobe raised.
   function automatic outcome_type plain(input logic [7:0] pc, input logic [31:0] acc);
      outcome_type r;
      r = '0;
      r.pc = pc;
      r.acc = acc;
      return r;
   endfunction

   // Execute one instruction on the shadow machine and return what the block must report.
   function automatic outcome_type exec_instr(input logic [4:0] op, input logic [31:0] val,
                                              input logic [7:0] tgt, input logic [7:0] ent);
      outcome_type r;
      logic [7:0]  step_pc;
      r = '0;
      step_pc = vm_pc + 8'd1;
      if (!vm_halted) begin
         executed_ops[op] = 1'b1;
         case (op)
            OP_NOP: vm_pc = step_pc;
            OP_LDI, OP_LD: begin
               vm_acc = val;
               vm_pc = step_pc;
            end
            OP_RSV_A, OP_RSV_B, OP_RSV_C: begin
            end
            OP_ST: begin
               r.st = 1'b1;
               r.entry = ent;
               vm_pc = step_pc;
            end
            OP_LT: begin
               vm_acc = ($signed(vm_acc) < $signed(val)) ? 32'd1 : 32'd0;
               vm_pc = step_pc;
            end
            OP_GT: begin
               vm_acc = ($signed(vm_acc) > $signed(val)) ? 32'd1 : 32'd0;
               vm_pc = step_pc;
            end
            OP_LTE: begin
               vm_acc = ($signed(vm_acc) <= $signed(val)) ? 32'd1 : 32'd0;
               vm_pc = step_pc;
            end
            OP_GTE: begin
               vm_acc = ($signed(vm_acc) >= $signed(val)) ? 32'd1 : 32'd0;
               vm_pc = step_pc;
            end
            OP_EQI, OP_EQ: begin
               vm_acc = (vm_acc == val) ? 32'd1 : 32'd0;
               vm_pc = step_pc;
            end
            OP_BZ:  vm_pc = (vm_acc == 32'd0) ? tgt : step_pc;
            OP_BNZ: vm_pc = (vm_acc != 32'd0) ? tgt : step_pc;
            OP_DLY: begin
               r.dl = 1'b1;
               vm_pc = step_pc;
            end
            OP_JMP: vm_pc = tgt;
            OP_ADDI, OP_ADD: begin
               vm_acc = vm_acc + val;
               vm_pc = step_pc;
            end
            OP_SUBI, OP_SUB: begin
               vm_acc = vm_acc - val;
               vm_pc = step_pc;
            end
            // Halt, and every code from OP_LIMIT up: freeze pc, raise the flag.
            default: vm_halted = 1'b1;
         endcase
      end else begin
         ignored_items++;
      end
      r.pc = vm_pc;
      r.acc = vm_acc;
      r.halted = vm_halted;
      if (r.st) r.sdata = vm_acc;
      if (r.dl) r.ticks = vm_acc;
      return r;
   endfunction

   // Operand source: extremes, values next to the accumulator, or anything at all.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return vm_acc;
         5: return vm_acc + $urandom_range(0, 2) - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Present one instruction, hold it until the transfer, then log its outcome.
   task automatic issue(input logic [4:0] op, input logic [31:0] val, input logic [7:0] tgt,
                        input logic [7:0] ent, input logic typed, input outcome_type want);
      outcome_type predicted;
      int          gap;
      if (!idle_off && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, ent, tgt, val, op};
      do @(posedge clock); while (!req_tready);
      predicted = exec_instr(op, val, tgt, ent);
      vm_results_due.push_back(typed ? want : predicted);
   endtask

   // Hold off the sender until the block has drained every outstanding result.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (vm_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Receive side: check each rsp transfer, then decide whether to stall next cycle.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (vm_results_due.size() == 0) begin
            $error("rsp transfer with no instruction outstanding");
            mismatch_count++;
         end else begin
            want = vm_results_due.pop_front();
            results_seen++;
            if (want.st) store_hits++;
            if (want.dl) delay_hits++;
            compare_field("next_pc",      want.pc,     rsp_tdata[7:0]);
            compare_field("acc_value",    want.acc,    rsp_tdata[39:8]);
            compare_field("halted",       want.halted, rsp_tdata[40]);
            compare_field("store_entry",  want.entry,  rsp_tdata[48:41]);
            compare_field("store_data",   want.sdata,  rsp_tdata[80:49]);
            compare_field("delay_ticks",  want.ticks,  rsp_tdata[112:81]);
            compare_field("store_strobe", want.st,     rsp_tuser[0]);
            compare_field("delay_strobe", want.dl,     rsp_tuser[1]);
         end
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
         rsp_stall_left = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [4:0]  op;
      logic [31:0] val;
      int          calm_from;

      // Directed walk from reset: wraps at both accumulator extremes, strobes at
      // the extreme entries, compares on both sides, taken and untaken branches,
      // reserved codes and a pc wrap from 255 to 0.
      dir_tbl = '{
         '{OP_NOP,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, plain(8'h01, 32'h0)},
         '{OP_LDI,  32'h7FFF_FFFF, 8'h00, 8'h00, 1'b1, plain(8'h02, 32'h7FFF_FFFF)},
         '{OP_ADDI, 32'h0000_0001, 8'h00, 8'h00, 1'b1, plain(8'h03, 32'h8000_0000)},
         '{OP_SUBI, 32'h0000_0001, 8'h00, 8'h00, 1'b1, plain(8'h04, 32'h7FFF_FFFF)},
         '{OP_LD,   32'h8000_0000, 8'h00, 8'h00, 1'b1, plain(8'h05, 32'h8000_0000)},
         '{OP_ST,   32'h0000_0000, 8'h00, 8'hFF, 1'b1,
           '{8'h06, 32'h8000_0000, 1'b0, 1'b1, 8'hFF, 32'h8000_0000, 1'b0, 32'h0}},
         '{OP_DLY,  32'h0000_0000, 8'h00, 8'h00, 1'b1,
           '{8'h07, 32'h8000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b1, 32'h8000_0000}},
         '{OP_LT,   32'h7FFF_FFFF, 8'h00, 8'h00, 1'b0, '0},
         '{OP_GT,   32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_LTE,  32'h0000_0001, 8'h00, 8'h00, 1'b0, '0},
         '{OP_GTE,  32'h0000_0002, 8'h00, 8'h00, 1'b0, '0},
         '{OP_BZ,   32'h0000_0000, 8'hAA, 8'h00, 1'b1, plain(8'hAA, 32'h0)},
         '{OP_BNZ,  32'h0000_0000, 8'h55, 8'h00, 1'b0, '0},
         '{OP_EQI,  32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_BNZ,  32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_EQ,   32'h0000_0005, 8'h00, 8'h00, 1'b0, '0},
         '{OP_RSV_A, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, plain(8'h01, 32'h0)},
         '{OP_RSV_B, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, plain(8'h01, 32'h0)},
         '{OP_RSV_C, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, plain(8'h01, 32'h0)},
         '{OP_JMP,  32'h0000_0000, 8'hFF, 8'h00, 1'b1, plain(8'hFF, 32'h0)},
         '{OP_NOP,  32'h0000_0000, 8'h00, 8'h00, 1'b1, plain(8'h00, 32'h0)},
         '{OP_ADD,  32'hFFFF_FFFF, 8'h00, 8'h00, 1'b0, '0},
         '{OP_SUB,  32'h8000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_ST,   32'h0000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_GTE,  32'h8000_0000, 8'h00, 8'h00, 1'b0, '0},
         '{OP_BZ,   32'h0000_0000, 8'h10, 8'h00, 1'b0, '0},
         '{OP_LTE,  32'h8000_0000, 8'h00, 8'h00, 1'b0, '0}
      };

      // Hold reset at the start, then release it once for good.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         issue(dir_tbl[i].op, dir_tbl[i].val, dir_tbl[i].tgt, dir_tbl[i].ent,
               dir_tbl[i].typed, dir_tbl[i].want);
      end
      drain();

      // Random programs of runnable instructions. Halt stays out: it is final,
      // since the machine only leaves it through reset.
      calm_from = RAND_ITEMS - CALM_ITEMS;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == RAND_ITEMS / 2) drain();
         // Switch idling off for whole stretches now and then, and for the tail.
         if (i % 100 == 0) idle_off = ($urandom_range(0, 2) == 0);
         if (i >= calm_from) idle_off = 1'b1;
         do op = $urandom_range(0, OP_SUB); while (op == OP_HALT);
         val = pick_value();
         issue(op, val, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0, '0);
      end

      // Stop the machine with either the halt code or an out-of-range one,
      // then confirm that nothing moves it afterwards.
      if ($urandom_range(0, 1) != 0) op = OP_HALT;
      else op = $urandom_range(OP_LIMIT, OP_TOP);
      issue(op, $urandom, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0, '0);
      for (int i = 0; i < AFTER_HALT; i++) begin
         op = $urandom_range(0, OP_TOP);
         issue(op, $urandom, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // Let the last results drain, then leave the block idle before the report.
      while (vm_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Executed %0d distinct opcodes, %0d results checked, %0d stores, %0d delays",
               $countones(executed_ops), results_seen, store_hits, delay_hits);
      $display("Final state: pc 0x%0h, halted %0b, %0d items offered after the stop",
               vm_pc, vm_halted, ignored_items);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/avm_pkg.sv
rtl/avm_exec.sv
rtl/accumulator_vm_execute.sv
sim/accumulator_vm_execute_tb.sv
